// ----- rtl/core/htt_pkg.sv -----
`timescale 1ns / 1ps

package htt_pkg;

  localparam int HTT_INDEX_BITS = 16;
  localparam int HTT_QDEPTH     = 8;
  localparam int HTT_NSTG       = 7;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

  localparam logic [63:0] HTT_GOLDEN = 64'h0000_0000_9e37_79b9;

  localparam int SH_A = 18;
  localparam int SH_B = 31;
  localparam int SH_C = 11;
  localparam int SH_D = 22;

  typedef struct packed {
    logic        kind;
    logic [31:0] key;
    logic [31:0] score;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  function automatic logic [63:0] hash_combine(input logic [63:0] k, input logic [63:0] v);
    return k ^ (v + HTT_GOLDEN + (k << 6) + (k >> 2));
  endfunction

endpackage

// ----- rtl/core/htt_front.sv -----
`timescale 1ns / 1ps

module htt_front import htt_pkg::*; #(
  parameter int QDEPTH = HTT_QDEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_kind,
  input  logic [63:0]  in_farmer_cards,
  input  logic [63:0]  in_lord_cards,
  input  logic [63:0]  in_last_move_cards,
  input  logic         in_side_to_move,
  input  logic [31:0]  in_store_score,
  input  back_stat_t   stat,
  output logic         push,
  output item_t        push_item
);

  localparam int OCC_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [31:0] score;
    logic [63:0] lord;
    logic [63:0] last;
    logic        turn;
    logic [63:0] k;
  } hstg_t;

  hstg_t              stg_r   [HTT_NSTG];
  hstg_t              stg_nxt [HTT_NSTG];
  logic [HTT_NSTG-1:0] vld_r;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic               accept;

  // occupancy covers items in the hash pipe plus items queued
  assign in_stall = stat.clearing || (occ_r == OCC_W'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    occ_nxt = occ_r;
    if (accept && !stat.pop) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!accept && stat.pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_comb begin
    hstg_t s;
    logic [63:0] m;
    stg_nxt[0].kind  = in_kind;
    stg_nxt[0].score = in_store_score;
    stg_nxt[0].lord  = in_lord_cards;
    stg_nxt[0].last  = in_last_move_cards;
    stg_nxt[0].turn  = in_side_to_move;
    stg_nxt[0].k     = in_farmer_cards + HTT_GOLDEN;

    s = stg_r[0];
    s.k = hash_combine(stg_r[0].k, stg_r[0].lord);
    stg_nxt[1] = s;

    s = stg_r[1];
    s.k = hash_combine(stg_r[1].k, stg_r[1].last);
    stg_nxt[2] = s;

    s = stg_r[2];
    s.k = hash_combine(stg_r[2].k, {63'd0, stg_r[2].turn});
    stg_nxt[3] = s;

    s = stg_r[3];
    m = (~stg_r[3].k) + (stg_r[3].k << SH_A);
    s.k = m ^ (m >> SH_B);
    stg_nxt[4] = s;

    s = stg_r[4];
    m = stg_r[4].k + (stg_r[4].k << 2) + (stg_r[4].k << 4);
    s.k = m ^ (m >> SH_C);
    stg_nxt[5] = s;

    s = stg_r[5];
    m = stg_r[5].k + (stg_r[5].k << 6);
    s.k = m ^ (m >> SH_D);
    stg_nxt[6] = s;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HTT_NSTG; i++) begin
      stg_r[i] <= stg_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      occ_r <= '0;
    end else begin
      vld_r <= {vld_r[HTT_NSTG-2:0], accept};
      occ_r <= occ_nxt;
    end
  end

  assign push            = vld_r[HTT_NSTG-1];
  assign push_item.kind  = stg_r[HTT_NSTG-1].kind;
  assign push_item.key   = stg_r[HTT_NSTG-1].k[31:0];
  assign push_item.score = stg_r[HTT_NSTG-1].score;

endmodule

// ----- rtl/core/htt_queue.sv -----
`timescale 1ns / 1ps

module htt_queue import htt_pkg::*; #(
  parameter int QDEPTH = HTT_QDEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t            buf_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_valid = (cnt_r != '0);
  assign head_item  = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CNT_W'(QDEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue pop while empty");
`endif

endmodule

// ----- rtl/core/htt_back.sv -----
`timescale 1ns / 1ps

module htt_back import htt_pkg::*; #(
  parameter int INDEX_BITS = HTT_INDEX_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  item_t              head_item,
  output back_stat_t         stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_found_score
);

  localparam int DEPTH = 1 << INDEX_BITS;

  logic [63:0]           mem [DEPTH];
  logic [63:0]           mem_q_r;
  logic                  clearing_r;
  logic [INDEX_BITS-1:0] clr_cnt_r;
  logic                  rd_pend_r;
  logic [31:0]           pend_key_r;
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [31:0]           out_score_r;

  logic                  pop;
  logic                  is_store;
  logic                  we;
  logic                  re;
  logic [INDEX_BITS-1:0] waddr;
  logic [63:0]           wdata;
  logic                  hit;

  assign is_store = (head_item.kind == KIND_STORE);
  // a lookup leaves only when the result register is sure to be free
  assign pop = !clearing_r && head_valid &&
               (is_store || (!rd_pend_r && (!out_valid_r || !out_stall)));
  assign re  = pop && !is_store;
  assign we  = clearing_r || (pop && is_store);

  always_comb begin
    if (clearing_r) begin
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      waddr = head_item.key[INDEX_BITS-1:0];
      wdata = {head_item.key ^ head_item.score, head_item.score};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[head_item.key[INDEX_BITS-1:0]];
    end
  end

  assign hit = ((mem_q_r[63:32] ^ mem_q_r[31:0]) == pend_key_r);

  always_ff @(posedge clk) begin
    if (re) begin
      pend_key_r <= head_item.key;
    end
    if (rd_pend_r) begin
      out_hit_r   <= hit;
      out_score_r <= hit ? mem_q_r[31:0] : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + INDEX_BITS'(1);
        if (clr_cnt_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      rd_pend_r <= re;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clearing   = clearing_r;
  assign stat.pop        = pop;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_score = out_score_r;

`ifndef ASSERT_OFF
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !pop)
    else $error("item taken during clearing pass");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("lookup result would overwrite pending result");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(rd_pend_r))
    else $error("result without memory read");
`endif

endmodule

// ----- rtl/core/hashed_transposition_table.sv -----
`timescale 1ns / 1ps

// Channel  Ports                                         Transfer
// in       in_valid/in_stall, in_kind, in_*_cards,        in_valid & !in_stall
//          in_side_to_move, in_store_score
// out      out_valid/out_stall, out_hit, out_found_score  out_valid & !out_stall
//
// The hash pipe registers each item through stg_r; a store is written to memory
// as it leaves the queue, a lookup takes a registered memory read, then a compare
// into the result register. A lookup leaves the queue only while no read is
// pending and the result register is free or being taken.
// After reset a clearing pass writes zero to all 2^INDEX_BITS entries, one per
// cycle; in_stall stays high for those cycles.
// Output stall backs up through the queue to in_stall via an occupancy count.

module hashed_transposition_table import htt_pkg::*; #(
  parameter int INDEX_BITS = HTT_INDEX_BITS,
  parameter int QDEPTH     = HTT_QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [63:0]        in_farmer_cards,
  input  logic [63:0]        in_lord_cards,
  input  logic [63:0]        in_last_move_cards,
  input  logic               in_side_to_move,
  input  logic signed [31:0] in_store_score,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_found_score
);

  back_stat_t stat;
  logic       push;
  item_t      push_item;
  logic       head_valid;
  item_t      head_item;

  htt_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_farmer_cards    (in_farmer_cards),
    .in_lord_cards      (in_lord_cards),
    .in_last_move_cards (in_last_move_cards),
    .in_side_to_move    (in_side_to_move),
    .in_store_score     (in_store_score),
    .stat               (stat),
    .push               (push),
    .push_item          (push_item)
  );

  htt_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (stat.pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  htt_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_score (out_found_score)
  );

endmodule
